// ===== hdl/u8f_pkg.sv =====
package u8f_pkg;

   // Tick input and per-tick result
   typedef struct packed {
      logic       rx_line;
      logic       push_valid;
      logic [7:0] push_data;
      logic       pop_request;
   } req_type;

   typedef struct packed {
      logic       tx_line;
      logic       push_accepted;
      logic       pop_valid;
      logic [7:0] pop_data;
      logic [4:0] rx_available;
      logic [7:0] rx_error_count;
      logic [7:0] rx_drop_count;
      logic       tx_busy;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  reg_index;
      logic [15:0] wdata;
   } csr_type;

   // Register indexes
   localparam logic [7:0] CSR_BIT_PERIOD    = 8'd0;
   localparam logic [7:0] CSR_SAMPLE_OFFSET = 8'd1;

   localparam logic [15:0] BIT_PERIOD_RESET    = 16'd26;
   localparam logic [15:0] SAMPLE_OFFSET_RESET = 16'd3;

   // Transmit phases: 0 frame boundary, 1 start scheduled, 2..9 data bits
   localparam logic [3:0] TX_PHASE_IDLE  = 4'd0;
   localparam logic [3:0] TX_PHASE_START = 4'd1;
   localparam logic [3:0] TX_PHASE_DATA0 = 4'd2;
   localparam logic [3:0] TX_PHASE_LAST  = 4'd9;

   // Receive bit index: 1..8 data bits, 9 stop bit
   localparam logic [3:0] RX_BIT_FIRST = 4'd1;
   localparam logic [3:0] RX_BIT_STOP  = 4'd9;

endpackage

// ===== hdl/u8f_chan_if.sv =====
interface u8f_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/u8f_ram.sv =====
module u8f_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/uart_8n1_with_fifos.sv =====
// Tick-driven 8N1 UART with receive and transmit FIFOs.
// Throughput: one tick per cycle unless the result channel stalls; the state
// update is a single pass from the input register to the result register,
// FIFO heads prefetched from the RAMs.
// Reset (synchronous, active high) empties both FIFOs, idles both directions,
// drives the line high and restores bit period 26 and sample offset 3.
module uart_8n1_with_fifos
   import u8f_pkg::*;
#(
   parameter int RX_FIFO_DEPTH = 32,
   parameter int TX_FIFO_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   u8f_chan_if.sink   req_if,
   u8f_chan_if.source rsp_if,
   u8f_chan_if.sink   csr_if
);

   localparam int RXW = $clog2(RX_FIFO_DEPTH);
   localparam int TXW = $clog2(TX_FIFO_DEPTH);
   localparam int AVW = RXW + 5;
   localparam logic [AVW-1:0] RX_DEPTH_W = AVW'(RX_FIFO_DEPTH);

   function automatic logic [RXW-1:0] rx_inc(input logic [RXW-1:0] p);
      return (p == RXW'(RX_FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [TXW-1:0] tx_inc(input logic [TXW-1:0] p);
      return (p == TXW'(TX_FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // configuration
   logic [15:0] bit_period_ff, sample_offset_ff;

   // pipeline
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_item_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    advance, req_accept;

   // receiver state
   logic [RXW-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic           rx_active_ff, rx_active_in;
   logic [3:0]     rx_bit_index_ff, rx_bit_index_in;
   logic [16:0]    rx_wait_ff, rx_wait_in;
   logic [7:0]     rx_shift_ff, rx_shift_in;
   logic [7:0]     err_count_ff, err_count_in;
   logic [7:0]     drop_count_ff, drop_count_in;
   logic           rx_we, rx_pop;
   logic [2:0]     rx_bit_sel;
   logic [7:0]     rx_pop_data;

   // transmitter state
   logic [TXW-1:0] tx_head_ff, tx_head_mid, tx_tail_ff, tx_tail_in, tx_next_tail;
   logic [3:0]     tx_phase_ff, tx_phase_in, tx_bit_sel;
   logic [15:0]    tx_wait_ff, tx_wait_mid, tx_wait_in;
   logic [7:0]     tx_shift_ff, tx_shift_in;
   logic           tx_running_ff, tx_run_mid, tx_running_in;
   logic           tx_level_ff, tx_level_in, tx_pending;
   logic           tx_we;

   // head prefetch with write bypass
   logic [RXW-1:0] rx_raddr;
   logic [TXW-1:0] tx_raddr;
   logic [7:0]     rx_rdata, tx_rdata, rx_head_data, tx_head_data;
   logic           rx_byp_ff, tx_byp_ff;
   logic [7:0]     rx_byp_data_ff, tx_byp_data_ff;

   logic [AVW-1:0] rx_tail_w, rx_head_w, rx_avail_w;

   // handshakes
   assign advance       = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready  = !s1_valid_ff || advance;
   assign req_accept    = req_if.valid && req_if.ready;
   assign csr_if.ready  = 1'b1;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   assign s1_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   assign rx_head_data = rx_byp_ff ? rx_byp_data_ff : rx_rdata;
   assign tx_head_data = tx_byp_ff ? tx_byp_data_ff : tx_rdata;

   // transmitter: timer event, then push
   assign tx_bit_sel = tx_phase_ff - TX_PHASE_DATA0;

   always_comb begin
      case (tx_phase_ff)
         TX_PHASE_IDLE:  tx_pending = 1'b1;
         TX_PHASE_START: tx_pending = 1'b0;
         default:        tx_pending = tx_shift_ff[tx_bit_sel[2:0]];
      endcase
   end

   always_comb begin
      tx_head_mid = tx_head_ff;
      tx_phase_in = tx_phase_ff;
      tx_wait_mid = tx_wait_ff;
      tx_shift_in = tx_shift_ff;
      tx_run_mid  = tx_running_ff;
      tx_level_in = tx_level_ff;
      if (tx_running_ff) begin
         if (tx_wait_ff > 16'd1) begin
            tx_wait_mid = tx_wait_ff - 16'd1;
         end else begin
            tx_wait_mid = bit_period_ff;
            tx_level_in = tx_pending;
            if (tx_phase_ff == TX_PHASE_IDLE) begin
               if (tx_head_ff == tx_tail_ff) begin
                  tx_run_mid = 1'b0;
               end else begin
                  tx_shift_in = tx_head_data;
                  tx_head_mid = tx_inc(tx_head_ff);
                  tx_phase_in = TX_PHASE_START;
               end
            end else if (tx_phase_ff >= TX_PHASE_LAST) begin
               tx_phase_in = TX_PHASE_IDLE;
            end else begin
               tx_phase_in = tx_phase_ff + 4'd1;
            end
         end
      end
      tx_next_tail  = tx_inc(tx_tail_ff);
      tx_we         = s1_item_ff.push_valid && (tx_next_tail != tx_head_mid);
      tx_tail_in    = tx_we ? tx_next_tail : tx_tail_ff;
      tx_running_in = tx_run_mid || tx_we;
      tx_wait_in    = (tx_we && !tx_run_mid) ? bit_period_ff : tx_wait_mid;
   end

   // receiver, then pop
   assign rx_bit_sel = 3'(rx_bit_index_ff - RX_BIT_FIRST);

   always_comb begin
      rx_active_in    = rx_active_ff;
      rx_bit_index_in = rx_bit_index_ff;
      rx_wait_in      = rx_wait_ff;
      rx_shift_in     = rx_shift_ff;
      rx_tail_in      = rx_tail_ff;
      err_count_in    = err_count_ff;
      drop_count_in   = drop_count_ff;
      rx_we           = 1'b0;
      if (!rx_active_ff) begin
         if (!s1_item_ff.rx_line) begin
            rx_active_in    = 1'b1;
            rx_bit_index_in = RX_BIT_FIRST;
            rx_shift_in     = 8'd0;
            rx_wait_in      = {1'b0, bit_period_ff} + {1'b0, sample_offset_ff};
         end
      end else if (rx_wait_ff > 17'd1) begin
         rx_wait_in = rx_wait_ff - 17'd1;
      end else if (rx_bit_index_ff >= RX_BIT_STOP) begin
         rx_active_in    = 1'b0;
         rx_bit_index_in = 4'd0;
         if (s1_item_ff.rx_line) begin
            if (rx_inc(rx_tail_ff) != rx_head_ff) begin
               rx_we      = 1'b1;
               rx_tail_in = rx_inc(rx_tail_ff);
            end else begin
               drop_count_in = drop_count_ff + 8'd1;
            end
         end else begin
            err_count_in = err_count_ff + 8'd1;
         end
      end else begin
         rx_shift_in     = rx_shift_ff | (8'(s1_item_ff.rx_line) << rx_bit_sel);
         rx_bit_index_in = rx_bit_index_ff + 4'd1;
         rx_wait_in      = {1'b0, bit_period_ff};
      end
      rx_pop = s1_item_ff.pop_request && (rx_head_ff != rx_tail_in);
      // a frame landing in an empty FIFO can be popped in the same tick
      rx_pop_data = (rx_we && (rx_tail_ff == rx_head_ff)) ? rx_shift_ff : rx_head_data;
      rx_head_in  = rx_pop ? rx_inc(rx_head_ff) : rx_head_ff;
   end

   assign rx_tail_w  = AVW'(rx_tail_in);
   assign rx_head_w  = AVW'(rx_head_in);
   assign rx_avail_w = (rx_tail_w >= rx_head_w) ? (rx_tail_w - rx_head_w)
                                                : (rx_tail_w + RX_DEPTH_W - rx_head_w);

   always_comb begin
      rsp_data_in.tx_line        = tx_level_in;
      rsp_data_in.push_accepted  = tx_we;
      rsp_data_in.pop_valid      = rx_pop;
      rsp_data_in.pop_data       = rx_pop ? rx_pop_data : 8'd0;
      rsp_data_in.rx_available   = rx_avail_w[4:0];
      rsp_data_in.rx_error_count = err_count_in;
      rsp_data_in.rx_drop_count  = drop_count_in;
      rsp_data_in.tx_busy        = tx_running_in;
   end

   assign rx_raddr = advance ? rx_head_in : rx_head_ff;
   assign tx_raddr = advance ? tx_head_mid : tx_head_ff;

   u8f_ram #(.WIDTH(8), .DEPTH(RX_FIFO_DEPTH)) rx_ram (
      .clock (clock),
      .we    (advance && rx_we),
      .waddr (rx_tail_ff),
      .wdata (rx_shift_ff),
      .raddr (rx_raddr),
      .rdata (rx_rdata)
   );

   u8f_ram #(.WIDTH(8), .DEPTH(TX_FIFO_DEPTH)) tx_ram (
      .clock (clock),
      .we    (advance && tx_we),
      .waddr (tx_tail_ff),
      .wdata (s1_item_ff.push_data),
      .raddr (tx_raddr),
      .rdata (tx_rdata)
   );

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= req_if.payload;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
      rx_byp_data_ff <= rx_shift_ff;
      tx_byp_data_ff <= s1_item_ff.push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff    <= BIT_PERIOD_RESET;
         sample_offset_ff <= SAMPLE_OFFSET_RESET;
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         rx_head_ff       <= '0;
         rx_tail_ff       <= '0;
         rx_active_ff     <= 1'b0;
         rx_bit_index_ff  <= 4'd0;
         rx_wait_ff       <= 17'd0;
         rx_shift_ff      <= 8'd0;
         err_count_ff     <= 8'd0;
         drop_count_ff    <= 8'd0;
         tx_head_ff       <= '0;
         tx_tail_ff       <= '0;
         tx_phase_ff      <= TX_PHASE_IDLE;
         tx_wait_ff       <= 16'd0;
         tx_shift_ff      <= 8'd0;
         tx_running_ff    <= 1'b0;
         tx_level_ff      <= 1'b1;
         rx_byp_ff        <= 1'b0;
         tx_byp_ff        <= 1'b0;
      end else begin
         if (csr_if.valid) begin
            case (csr_if.payload.reg_index)
               CSR_BIT_PERIOD:    bit_period_ff    <= csr_if.payload.wdata;
               CSR_SAMPLE_OFFSET: sample_offset_ff <= csr_if.payload.wdata;
               default: ;
            endcase
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         // RAM reads old data on a same-address write: remember the new byte
         rx_byp_ff <= advance && rx_we && (rx_tail_ff == rx_raddr);
         tx_byp_ff <= advance && tx_we && (tx_tail_ff == tx_raddr);
         if (advance) begin
            rx_head_ff      <= rx_head_in;
            rx_tail_ff      <= rx_tail_in;
            rx_active_ff    <= rx_active_in;
            rx_bit_index_ff <= rx_bit_index_in;
            rx_wait_ff      <= rx_wait_in;
            rx_shift_ff     <= rx_shift_in;
            err_count_ff    <= err_count_in;
            drop_count_ff   <= drop_count_in;
            tx_head_ff      <= tx_head_mid;
            tx_tail_ff      <= tx_tail_in;
            tx_phase_ff     <= tx_phase_in;
            tx_wait_ff      <= tx_wait_in;
            tx_shift_ff     <= tx_shift_in;
            tx_running_ff   <= tx_running_in;
            tx_level_ff     <= tx_level_in;
         end
      end
   end

   // an idle transmitter always leaves the line high
   assert property (@(posedge clock) disable iff (reset) !tx_running_ff |-> tx_level_ff)
      else $error("tx idle with line low");

   assert property (@(posedge clock) disable iff (reset)
                    tx_phase_ff <= TX_PHASE_LAST && rx_bit_index_ff <= RX_BIT_STOP)
      else $error("frame phase out of range");

   assert property (@(posedge clock) disable iff (reset)
                    !rx_active_ff |-> rx_bit_index_ff == 4'd0)
      else $error("rx bit index set while idle");

   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid_ff && !rsp_data_ff.pop_valid |-> rsp_data_ff.pop_data == 8'd0)
      else $error("pop data without pop");

endmodule

// ===== tb/sv/uart_8n1_with_fifos_tb.sv =====
module uart_8n1_with_fifos_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import u8f_pkg::*;

   localparam int FIFO_DEPTH = 32;

   logic clock;
   logic reset;

   u8f_chan_if #(.payload_type(req_type)) req_ch ();
   u8f_chan_if #(.payload_type(rsp_type)) rsp_ch ();
   u8f_chan_if #(.payload_type(csr_type)) csr_ch ();

   uart_8n1_with_fifos dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // idle rates, percent per cycle
   int send_idle_pct;
   int rsp_stall_pct;
   int fail_count;

   // per-tick status the block should report, oldest first
   rsp_type tick_status_q[$];

   // predictor copy of the registers and state
   logic [15:0] bit_period;
   logic [15:0] sample_offset;

   logic [7:0]  tx_fifo_mem [FIFO_DEPTH];
   logic [4:0]  tx_rd_ptr, tx_wr_ptr;
   logic [3:0]  tx_bit_phase;
   logic [15:0] tx_countdown;
   logic [7:0]  tx_byte;
   logic        tx_on;
   logic        tx_out;

   logic [7:0]  rx_fifo_mem [FIFO_DEPTH];
   logic [4:0]  rx_rd_ptr, rx_wr_ptr;
   logic        rx_busy;
   logic [3:0]  rx_bit_num;
   logic [16:0] rx_countdown;
   logic [7:0]  rx_byte;
   logic [7:0]  frame_err_cnt;
   logic [7:0]  overrun_cnt;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   task automatic reset_uart_model();
      bit_period    = BIT_PERIOD_RESET;
      sample_offset = SAMPLE_OFFSET_RESET;
      tx_rd_ptr     = '0;
      tx_wr_ptr     = '0;
      tx_bit_phase  = TX_PHASE_IDLE;
      tx_countdown  = '0;
      tx_byte       = '0;
      tx_on         = 1'b0;
      tx_out        = 1'b1;
      rx_rd_ptr     = '0;
      rx_wr_ptr     = '0;
      rx_busy       = 1'b0;
      rx_bit_num    = '0;
      rx_countdown  = '0;
      rx_byte       = '0;
      frame_err_cnt = '0;
      overrun_cnt   = '0;
   endtask

   // One timer tick: transmit timer, then receiver, then push, then pop.
   task automatic uart_tick_model(input req_type t, output rsp_type r);
      logic [4:0] next_ptr;
      logic [3:0] sel;
      r = '0;

      if (tx_on) begin
         if (tx_countdown > 16'd1) begin
            tx_countdown = tx_countdown - 16'd1;
         end else begin
            tx_countdown = bit_period;
            // line takes the level scheduled by the previous event
            if (tx_bit_phase == TX_PHASE_IDLE) begin
               tx_out = 1'b1;
            end else if (tx_bit_phase == TX_PHASE_START) begin
               tx_out = 1'b0;
            end else begin
               sel = tx_bit_phase - TX_PHASE_DATA0;
               tx_out = tx_byte[sel[2:0]];
            end
            if (tx_bit_phase == TX_PHASE_IDLE) begin
               if (tx_rd_ptr == tx_wr_ptr) begin
                  tx_on = 1'b0;
               end else begin
                  tx_byte = tx_fifo_mem[tx_rd_ptr];
                  tx_rd_ptr = tx_rd_ptr + 5'd1;
                  tx_bit_phase = TX_PHASE_START;
               end
            end else if (tx_bit_phase >= TX_PHASE_LAST) begin
               tx_bit_phase = TX_PHASE_IDLE;
            end else begin
               tx_bit_phase = tx_bit_phase + 4'd1;
            end
         end
      end

      if (!rx_busy) begin
         if (!t.rx_line) begin
            rx_busy = 1'b1;
            rx_bit_num = RX_BIT_FIRST;
            rx_byte = '0;
            rx_countdown = {1'b0, bit_period} + {1'b0, sample_offset};
         end
      end else if (rx_countdown > 17'd1) begin
         rx_countdown = rx_countdown - 17'd1;
      end else if (rx_bit_num >= RX_BIT_STOP) begin
         rx_busy = 1'b0;
         rx_bit_num = '0;
         if (t.rx_line) begin
            next_ptr = rx_wr_ptr + 5'd1;
            if (next_ptr != rx_rd_ptr) begin
               rx_fifo_mem[rx_wr_ptr] = rx_byte;
               rx_wr_ptr = next_ptr;
            end else begin
               overrun_cnt = overrun_cnt + 8'd1;
            end
         end else begin
            frame_err_cnt = frame_err_cnt + 8'd1;
         end
      end else begin
         sel = rx_bit_num - RX_BIT_FIRST;
         rx_byte[sel[2:0]] = t.rx_line;
         rx_bit_num = rx_bit_num + 4'd1;
         rx_countdown = {1'b0, bit_period};
      end

      if (t.push_valid) begin
         next_ptr = tx_wr_ptr + 5'd1;
         if (next_ptr != tx_rd_ptr) begin
            tx_fifo_mem[tx_wr_ptr] = t.push_data;
            tx_wr_ptr = next_ptr;
            r.push_accepted = 1'b1;
            if (!tx_on) begin
               tx_on = 1'b1;
               tx_countdown = bit_period;
            end
         end
      end

      if (t.pop_request && rx_rd_ptr != rx_wr_ptr) begin
         r.pop_valid = 1'b1;
         r.pop_data = rx_fifo_mem[rx_rd_ptr];
         rx_rd_ptr = rx_rd_ptr + 5'd1;
      end

      r.tx_line        = tx_out;
      r.rx_available   = rx_wr_ptr - rx_rd_ptr;
      r.rx_error_count = frame_err_cnt;
      r.rx_drop_count  = overrun_cnt;
      r.tx_busy        = tx_on;
   endtask

   // ---------------- serial line shaping ----------------

   function automatic int bit_ticks();
      return (bit_period == 16'd0) ? 1 : int'(bit_period);
   endfunction

   // Start-bit length chosen so every receiver sample lands inside its bit.
   function automatic int lead_ticks();
      int pe, first;
      pe = bit_ticks();
      first = int'(bit_period) + int'(sample_offset);
      if (first == 0) first = 1;
      return (first - pe / 2 > pe) ? first - pe / 2 : pe;
   endfunction

   function automatic int frame_ticks();
      return lead_ticks() + 9 * bit_ticks();
   endfunction

   function automatic logic frame_level(input int pos, input logic [7:0] data,
                                        input logic stop_level);
      int pe, lead;
      pe = bit_ticks();
      lead = lead_ticks();
      if (pos < lead) return 1'b0;
      if (pos < lead + 8 * pe) return data[(pos - lead) / pe];
      return stop_level;
   endfunction

   function automatic req_type tick_of(input logic line, input logic push,
                                       input logic [7:0] data, input logic pop);
      req_type t;
      t.rx_line     = line;
      t.push_valid  = push;
      t.push_data   = data;
      t.pop_request = pop;
      return t;
   endfunction

   // ---------------- channel drivers ----------------

   task automatic send_tick(input req_type t);
      rsp_type r;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= t;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      uart_tick_model(t, r);
      tick_status_q.push_back(r);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (tick_status_q.size() != 0);
   endtask

   task automatic write_csr(input logic [7:0] idx, input logic [15:0] value);
      csr_type c;
      wait_drained();
      repeat (3) @(negedge clock);
      c.reg_index = idx;
      c.wdata = value;
      csr_ch.valid <= 1'b1;
      csr_ch.payload <= c;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      if (idx == CSR_BIT_PERIOD) bit_period = value;
      else if (idx == CSR_SAMPLE_OFFSET) sample_offset = value;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic set_baud(input logic [15:0] period, input logic [15:0] offset);
      write_csr(CSR_BIT_PERIOD, period);
      write_csr(CSR_SAMPLE_OFFSET, offset);
   endtask

   task automatic send_frame(input logic [7:0] data, input logic stop_level);
      int len;
      len = frame_ticks();
      for (int pos = 0; pos < len; pos++)
         send_tick(tick_of(frame_level(pos, data, stop_level), 1'b0, 8'h00, 1'b0));
   endtask

   // Frames at the programmed rate mixed with line glitches, pushes and pops.
   task automatic run_traffic(input int n_ticks, input int frame_pct, input int push_pct,
                              input int pop_pct, input bit hold_midway);
      req_type t;
      int pos, gap, len;
      logic [7:0] data;
      logic stop_level;
      pos = -1;
      gap = 0;
      data = '0;
      stop_level = 1'b1;
      len = frame_ticks();
      for (int i = 0; i < n_ticks; i++) begin
         if (hold_midway && i == n_ticks / 2) wait_drained();
         if (pos < 0 && gap == 0 && $urandom_range(0, 99) < frame_pct) begin
            pos = 0;
            data = 8'($urandom);
            stop_level = ($urandom_range(0, 99) >= 10);
         end
         if (pos >= 0) begin
            t.rx_line = frame_level(pos, data, stop_level);
            pos++;
            if (pos == len) begin
               pos = -1;
               gap = $urandom_range(0, 2);
            end
         end else if (gap > 0) begin
            t.rx_line = 1'b1;
            gap--;
         end else begin
            t.rx_line = ($urandom_range(0, 99) >= 3);
         end
         t.push_valid  = ($urandom_range(0, 99) < push_pct);
         t.push_data   = 8'($urandom);
         t.pop_request = ($urandom_range(0, 99) < pop_pct);
         send_tick(t);
      end
   endtask

   task automatic set_idling(input int send_pct, input int stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // ---------------- result checking ----------------

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.payload;
         if (tick_status_q.size() == 0) begin
            $display("%0t: result beat with no tick pending, got %0h", $time, got);
            fail_count++;
         end else begin
            want = tick_status_q.pop_front();
            check_field("tx_line", 8'(want.tx_line), 8'(got.tx_line));
            check_field("push_accepted", 8'(want.push_accepted), 8'(got.push_accepted));
            check_field("pop_valid", 8'(want.pop_valid), 8'(got.pop_valid));
            check_field("pop_data", want.pop_data, got.pop_data);
            check_field("rx_available", 8'(want.rx_available), 8'(got.rx_available));
            check_field("rx_error_count", want.rx_error_count, got.rx_error_count);
            check_field("rx_drop_count", want.rx_drop_count, got.rx_drop_count);
            check_field("tx_busy", 8'(want.tx_busy), 8'(got.tx_busy));
         end
      end
   end

   // ---------------- tests ----------------

   // out of reset: default baud, first push wakes the transmitter
   task automatic test_reset_defaults();
      send_tick(tick_of(1'b1, 1'b0, 8'h00, 1'b1));
      send_tick(tick_of(1'b1, 1'b1, 8'hA5, 1'b0));
      send_tick(tick_of(1'b1, 1'b0, 8'h00, 1'b0));
      send_tick(tick_of(1'b1, 1'b1, 8'h5A, 1'b1));
   endtask

   // zero period and offset act as one tick; data extremes; bad stop bit
   task automatic test_directed_edges();
      set_baud(16'd0, 16'd0);
      send_tick(tick_of(1'b1, 1'b0, 8'h00, 1'b1));
      send_tick(tick_of(1'b1, 1'b1, 8'h00, 1'b0));
      send_tick(tick_of(1'b1, 1'b1, 8'hFF, 1'b0));
      send_frame(8'hFF, 1'b1);
      send_frame(8'h00, 1'b0);
      send_tick(tick_of(1'b1, 1'b0, 8'h00, 1'b1));
      send_tick(tick_of(1'b1, 1'b0, 8'h00, 1'b1));
   endtask

   task automatic test_default_baud();
      set_idling(0, 0);
      set_baud(BIT_PERIOD_RESET, SAMPLE_OFFSET_RESET);
      run_traffic(250, 40, 5, 10, 1'b0);
   endtask

   task automatic test_sender_gaps();
      set_idling(48, 0);
      set_baud(16'd2, 16'd0);
      run_traffic(300, 50, 8, 15, 1'b0);
   endtask

   // no pops and heavy pushes: both FIFOs fill, frames get dropped
   task automatic test_fifo_overflow();
      set_idling(0, 48);
      set_baud(16'd2, 16'd1);
      run_traffic(800, 90, 50, 0, 1'b0);
   endtask

   // starts with a full receive FIFO; pauses once for all results mid-run
   task automatic test_mixed_stalls();
      set_idling(28, 28);
      set_baud(16'd3, 16'd2);
      run_traffic(300, 50, 10, 30, 1'b1);
   endtask

   task automatic test_slow_baud();
      set_idling(0, 0);
      set_baud(16'd5, 16'd4);
      run_traffic(200, 50, 10, 40, 1'b0);
   endtask

   // first sample delay beyond 16 bits: an idle stretch lets any open frame
   // finish, then the line stays low well past where a short delay would
   // have sampled a whole frame
   task automatic test_long_sample_delay();
      set_idling(0, 0);
      set_baud(16'd2, 16'hFFFF);
      send_tick(tick_of(1'b1, 1'b1, 8'h3C, 1'b1));
      for (int i = 0; i < 30; i++)
         send_tick(tick_of(1'b1, 1'b0, 8'h00, 1'b1));
      for (int i = 0; i < 40; i++)
         send_tick(tick_of(1'b0, 1'b0, 8'h00, 1'b1));
   endtask

   task automatic test_max_period();
      set_baud(16'hFFFF, 16'hFFFF);
      send_tick(tick_of(1'b1, 1'b1, 8'hC3, 1'b0));
      for (int i = 0; i < 60; i++)
         send_tick(tick_of(1'b0, 1'b0, 8'h00, 1'b1));
   endtask

   initial begin
      fail_count = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      csr_ch.valid = 1'b0;
      csr_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      reset_uart_model();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_directed_edges();
      test_default_baud();
      test_sender_gaps();
      test_fifo_overflow();
      test_mixed_stalls();
      test_slow_baud();
      test_long_sample_delay();
      test_max_period();

      wait_drained();
      repeat (5) @(negedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
